FILE: src/botc_pkg.sv
// Shared types, codes and constants of the bulk-only transport command engine.
package botc_pkg;

  localparam int unsigned MaxChunkBytes = 4096;
  localparam int unsigned QDepth        = 2;

  localparam logic [1:0] ACT_XFER   = 2'd0;
  localparam logic [1:0] ACT_STATUS = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  localparam logic [1:0] CFG_SSLOG2 = 2'd0;
  localparam logic [1:0] CFG_TOTAL  = 2'd1;
  localparam logic [1:0] CFG_FLUSH  = 2'd2;

  localparam logic KIND_CMD   = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_RO      = 3'd2;
  localparam logic [2:0] ST_IO      = 3'd3;
  localparam logic [2:0] ST_UNEXP   = 3'd4;
  localparam logic [2:0] ST_BUSY    = 3'd5;

  localparam logic [31:0] CSW_SIG  = 32'h5342_5355;
  localparam logic [7:0]  OP_RD10  = 8'h28;
  localparam logic [7:0]  OP_WR10  = 8'h2a;
  localparam logic [7:0]  OP_RD16  = 8'h88;
  localparam logic [7:0]  OP_WR16  = 8'h8a;
  localparam logic [7:0]  OP_SYNC  = 8'h35;
  localparam logic [4:0]  CDB_10   = 5'd10;
  localparam logic [4:0]  CDB_16   = 5'd16;

  // classified request held between front and back
  typedef struct packed {
    logic [1:0]  action;
    logic        wr;
    logic [63:0] lba;
    logic [31:0] count;
    logic        range_bad;
    logic        pre_broken;
    logic        st_zero;
    logic [31:0] csw_tag;
    logic [31:0] csw_residue;
    logic [12:0] moved;
  } fe_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status_code;
    logic [31:0] tag;
    logic [12:0] data_length;
    logic        direction_in;
    logic [4:0]  cdb_length;
    logic [7:0]  opcode;
    logic [63:0] cmd_lba;
    logic [3:0]  cmd_blocks;
    logic        abort_link;
  } res_t;

  typedef struct packed {
    logic push;
    logic kind;
    logic abort;
    logic busy;
    logic dead;
  } bk_stat_t;

endpackage

FILE: src/botc_front.sv
// Front end: classifies incoming requests and queues them for the back end.
module botc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  output logic           full_o,
  input  logic [1:0]     action_i,
  input  logic           write_i,
  input  logic [63:0]    lba_i,
  input  logic [31:0]    block_count_i,
  input  logic [31:0]    csw_signature_i,
  input  logic [31:0]    csw_tag_i,
  input  logic [31:0]    csw_residue_i,
  input  logic [7:0]     csw_status_i,
  input  logic           csw_length_ok_i,
  input  logic [12:0]    data_bytes_moved_i,
  input  logic           link_error_i,
  input  logic [63:0]    total_sectors_i,
  input  logic           pop_i,
  output logic           valid_o,
  output botc_pkg::fe_t  item_o
);

  botc_pkg::fe_t mem [botc_pkg::QDepth];
  logic          wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;
  botc_pkg::fe_t cls;
  logic [63:0]   room;

  assign room = total_sectors_i - lba_i;

  always_comb begin
    cls             = '0;
    cls.action      = action_i;
    cls.wr          = write_i;
    cls.lba         = lba_i;
    cls.count       = block_count_i;
    cls.range_bad   = (block_count_i == 32'd0) || (lba_i >= total_sectors_i) ||
                      ({32'd0, block_count_i} > room);
    cls.pre_broken  = link_error_i || !csw_length_ok_i ||
                      (csw_signature_i != botc_pkg::CSW_SIG) || (csw_status_i >= 8'd2);
    cls.st_zero     = (csw_status_i == 8'd0);
    cls.csw_tag     = csw_tag_i;
    cls.csw_residue = csw_residue_i;
    cls.moved       = data_bytes_moved_i;
  end

  assign full_o  = (cnt_r == 2'(botc_pkg::QDepth));
  assign valid_o = (cnt_r != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + 1'(do_push);
    rptr_nxt = rptr_r + 1'(do_pop);
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: src/botc_back.sv
// Back end: sequencing state, chunking and status validation.
module botc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  botc_pkg::fe_t      item_i,
  output logic               pop_o,
  input  logic               oq_full_i,
  input  logic [3:0]         sslog2_i,
  input  logic               flush_ok_i,
  output logic               push_o,
  output botc_pkg::res_t     res_o,
  output botc_pkg::bk_stat_t stat_o
);

  logic [31:0] last_tag_r, last_tag_nxt;
  logic        dead_r, dead_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] next_lba_r, next_lba_nxt;
  logic [31:0] left_r, left_nxt;
  logic        writing_r, writing_nxt;
  logic [3:0]  chunk_r, chunk_nxt;
  logic [12:0] exp_r, exp_nxt;

  logic        go;
  logic [3:0]  s;
  logic [3:0]  per;
  logic [63:0] em_lba, adv_lba;
  logic [31:0] em_left, adv_left, nm1;
  logic [3:0]  n;
  logic [13:0] bytes;
  logic [32:0] lo_sum;
  logic        cdb10;
  logic        em_wr;
  logic [12:0] actual;
  logic        broken;

  assign go    = valid_i && !oq_full_i;
  assign pop_o = go;
  assign push_o = go;

  always_comb begin
    if (sslog2_i < 4'd9) begin
      s = 4'd9;
    end else if (sslog2_i > 4'd12) begin
      s = 4'd12;
    end else begin
      s = sslog2_i;
    end
    per = 4'((botc_pkg::MaxChunkBytes >> 9) >> (s - 4'd9));
    if (per == 4'd0) begin
      per = 4'd1;
    end
  end

  assign adv_lba  = next_lba_r + {60'd0, chunk_r};
  assign adv_left = left_r - {28'd0, chunk_r};

  // chunk unit: shared by new transfers and by chunk advance
  always_comb begin
    if (item_i.action == botc_pkg::ACT_XFER) begin
      em_lba  = item_i.lba;
      em_left = item_i.count;
      em_wr   = item_i.wr;
    end else begin
      em_lba  = adv_lba;
      em_left = adv_left;
      em_wr   = writing_r;
    end
    n      = (em_left < {28'd0, per}) ? em_left[3:0] : per;
    bytes  = 14'({10'd0, n} << s);
    nm1    = {28'd0, n} - 32'd1;
    lo_sum = {1'b0, em_lba[31:0]} + {1'b0, nm1};
    cdb10  = (em_lba[63:32] == 32'd0) && !lo_sum[32];
  end

  always_comb begin
    actual = (exp_r != 13'd0) ? item_i.moved : 13'd0;
    broken = item_i.pre_broken ||
             ((exp_r != 13'd0) && writing_r && (actual != exp_r)) ||
             (item_i.csw_tag != last_tag_r) ||
             (item_i.csw_residue > {19'd0, exp_r}) ||
             (actual > exp_r) ||
             (item_i.st_zero && (item_i.csw_residue != {19'd0, exp_r - actual}));
  end

  always_comb begin
    last_tag_nxt = last_tag_r;
    dead_nxt     = dead_r;
    busy_nxt     = busy_r;
    next_lba_nxt = next_lba_r;
    left_nxt     = left_r;
    writing_nxt  = writing_r;
    chunk_nxt    = chunk_r;
    exp_nxt      = exp_r;
    res_o        = '0;
    res_o.kind   = botc_pkg::KIND_FINAL;
    if (go) begin
      unique case (item_i.action) inside
        botc_pkg::ACT_XFER, botc_pkg::ACT_STATUS: begin
          logic emit;
          emit = 1'b0;
          if (item_i.action == botc_pkg::ACT_XFER) begin
            if (busy_r) begin
              res_o.status_code = botc_pkg::ST_BUSY;
            end else if (item_i.range_bad) begin
              res_o.status_code = botc_pkg::ST_INVALID;
            end else if (item_i.wr && !flush_ok_i) begin
              res_o.status_code = botc_pkg::ST_RO;
            end else if (dead_r) begin
              res_o.status_code = botc_pkg::ST_IO;
            end else begin
              writing_nxt  = item_i.wr;
              next_lba_nxt = item_i.lba;
              left_nxt     = item_i.count;
              emit         = 1'b1;
            end
          end else begin
            if (!busy_r) begin
              res_o.status_code = botc_pkg::ST_UNEXP;
            end else if (broken) begin
              dead_nxt          = 1'b1;
              busy_nxt          = 1'b0;
              res_o.status_code = botc_pkg::ST_IO;
              res_o.abort_link  = 1'b1;
            end else if (!item_i.st_zero || (actual != exp_r)) begin
              busy_nxt          = 1'b0;
              res_o.status_code = botc_pkg::ST_IO;
            end else begin
              next_lba_nxt = adv_lba;
              left_nxt     = adv_left;
              if (adv_left == 32'd0) begin
                busy_nxt          = 1'b0;
                res_o.status_code = botc_pkg::ST_OK;
              end else begin
                emit = 1'b1;
              end
            end
          end
          if (emit) begin
            if (bytes > 14'(botc_pkg::MaxChunkBytes)) begin
              busy_nxt          = 1'b0;
              res_o.status_code = botc_pkg::ST_IO;
            end else begin
              busy_nxt           = 1'b1;
              last_tag_nxt       = last_tag_r + 32'd1;
              chunk_nxt          = n;
              exp_nxt            = bytes[12:0];
              res_o.kind         = botc_pkg::KIND_CMD;
              res_o.tag          = last_tag_r + 32'd1;
              res_o.data_length  = bytes[12:0];
              res_o.direction_in = !em_wr;
              res_o.cdb_length   = cdb10 ? botc_pkg::CDB_10 : botc_pkg::CDB_16;
              res_o.opcode       = cdb10 ? (em_wr ? botc_pkg::OP_WR10 : botc_pkg::OP_RD10)
                                         : (em_wr ? botc_pkg::OP_WR16 : botc_pkg::OP_RD16);
              res_o.cmd_lba      = em_lba;
              res_o.cmd_blocks   = n;
            end
          end
        end
        botc_pkg::ACT_FLUSH: begin
          if (busy_r) begin
            res_o.status_code = botc_pkg::ST_BUSY;
          end else if (!flush_ok_i) begin
            res_o.status_code = botc_pkg::ST_RO;
          end else if (dead_r) begin
            res_o.status_code = botc_pkg::ST_IO;
          end else begin
            busy_nxt         = 1'b1;
            writing_nxt      = 1'b1;
            next_lba_nxt     = 64'd0;
            left_nxt         = 32'd0;
            chunk_nxt        = 4'd0;
            exp_nxt          = 13'd0;
            last_tag_nxt     = last_tag_r + 32'd1;
            res_o.kind       = botc_pkg::KIND_CMD;
            res_o.tag        = last_tag_r + 32'd1;
            res_o.cdb_length = botc_pkg::CDB_10;
            res_o.opcode     = botc_pkg::OP_SYNC;
          end
        end
        default: begin
          res_o.status_code = botc_pkg::ST_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    stat_o.push  = go;
    stat_o.kind  = res_o.kind;
    stat_o.abort = res_o.abort_link;
    stat_o.busy  = busy_r;
    stat_o.dead  = dead_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tag_r <= 32'd0;
      dead_r     <= 1'b0;
      busy_r     <= 1'b0;
      next_lba_r <= 64'd0;
      left_r     <= 32'd0;
      writing_r  <= 1'b0;
      chunk_r    <= 4'd0;
      exp_r      <= 13'd0;
    end else begin
      last_tag_r <= last_tag_nxt;
      dead_r     <= dead_nxt;
      busy_r     <= busy_nxt;
      next_lba_r <= next_lba_nxt;
      left_r     <= left_nxt;
      writing_r  <= writing_nxt;
      chunk_r    <= chunk_nxt;
      exp_r      <= exp_nxt;
    end
  end

endmodule

FILE: src/botc_outq.sv
// Result queue: holds finished results until the consumer pops them.
module botc_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  botc_pkg::res_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output botc_pkg::res_t data_o
);

  botc_pkg::res_t mem [botc_pkg::QDepth];
  logic           wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full_o  = (cnt_r == 2'(botc_pkg::QDepth));
  assign empty_o = (cnt_r == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + 1'(do_push);
    rptr_nxt = rptr_r + 1'(do_pop);
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: src/bulk_only_transport_command_engine.sv
// Top level of the bulk-only transport command engine.
//   channel | direction | handshake          | carries
//   in_     | into      | push / full        | transfer, status or flush request
//   out_    | out of    | empty / pop        | command wrapper or final status
//   cfg_    | into      | valid / ready      | register index and write data
// One request per cycle while neither queue is full.
// The back end decides each request combinationally from its state registers.
// Two-entry queues before and after the back end let either side stall alone.
// Synchronous active-low reset clears all sequencing state and config to defaults.
module bulk_only_transport_command_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic        in_write,
  input  logic [63:0] in_lba,
  input  logic [31:0] in_block_count,
  input  logic [31:0] in_csw_signature,
  input  logic [31:0] in_csw_tag,
  input  logic [31:0] in_csw_residue,
  input  logic [7:0]  in_csw_status,
  input  logic        in_csw_length_ok,
  input  logic [12:0] in_data_bytes_moved,
  input  logic        in_link_error,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [2:0]  out_status_code,
  output logic [31:0] out_tag,
  output logic [12:0] out_data_length,
  output logic        out_direction_in,
  output logic [4:0]  out_cdb_length,
  output logic [7:0]  out_opcode,
  output logic [63:0] out_cmd_lba,
  output logic [3:0]  out_cmd_blocks,
  output logic        out_abort_link,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [3:0]  sslog2_r;
  logic [63:0] total_r;
  logic        flush_r;

  logic               fe_valid, fe_pop, oq_full, bk_push;
  botc_pkg::fe_t      fe_item;
  botc_pkg::res_t     bk_res, oq_res;
  botc_pkg::bk_stat_t bk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sslog2_r <= 4'd9;
      total_r  <= 64'd0;
      flush_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        botc_pkg::CFG_SSLOG2: sslog2_r <= cfg_data[3:0];
        botc_pkg::CFG_TOTAL:  total_r  <= cfg_data;
        botc_pkg::CFG_FLUSH:  flush_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  botc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push_i             (in_push),
    .full_o             (in_full),
    .action_i           (in_action),
    .write_i            (in_write),
    .lba_i              (in_lba),
    .block_count_i      (in_block_count),
    .csw_signature_i    (in_csw_signature),
    .csw_tag_i          (in_csw_tag),
    .csw_residue_i      (in_csw_residue),
    .csw_status_i       (in_csw_status),
    .csw_length_ok_i    (in_csw_length_ok),
    .data_bytes_moved_i (in_data_bytes_moved),
    .link_error_i       (in_link_error),
    .total_sectors_i    (total_r),
    .pop_i              (fe_pop),
    .valid_o            (fe_valid),
    .item_o             (fe_item)
  );

  botc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (fe_valid),
    .item_i     (fe_item),
    .pop_o      (fe_pop),
    .oq_full_i  (oq_full),
    .sslog2_i   (sslog2_r),
    .flush_ok_i (flush_r),
    .push_o     (bk_push),
    .res_o      (bk_res),
    .stat_o     (bk_stat)
  );

  botc_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (bk_push),
    .data_i  (bk_res),
    .full_o  (oq_full),
    .pop_i   (out_pop),
    .empty_o (out_empty),
    .data_o  (oq_res)
  );

  assign out_kind         = oq_res.kind;
  assign out_status_code  = oq_res.status_code;
  assign out_tag          = oq_res.tag;
  assign out_data_length  = oq_res.data_length;
  assign out_direction_in = oq_res.direction_in;
  assign out_cdb_length   = oq_res.cdb_length;
  assign out_opcode       = oq_res.opcode;
  assign out_cmd_lba      = oq_res.cmd_lba;
  assign out_cmd_blocks   = oq_res.cmd_blocks;
  assign out_abort_link   = oq_res.abort_link;

  // a command wrapper leaves the sequencer busy
  a_cmd_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.push && (bk_stat.kind == botc_pkg::KIND_CMD) |=> bk_stat.busy)
    else $error("command issued without entering busy");

  // an abort marks the link dead and ends the exchange
  a_abort_kills_link: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.push && bk_stat.abort |=> bk_stat.dead && !bk_stat.busy)
    else $error("abort did not mark link dead");

  // aborts only ride on final status results
  a_abort_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_abort_link |-> (out_kind == botc_pkg::KIND_FINAL))
    else $error("abort flagged on a command wrapper");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the bulk-only transport command engine.
`timescale 1ns / 1ps

module testbench;

  typedef enum int {FIX_NONE, FIX_GOOD, FIX_SHORT, FIX_FAILED} fix_t;

  typedef struct {
    logic [1:0]  action;
    logic        wr;
    logic [63:0] lba;
    logic [31:0] cnt;
    logic [31:0] sig;
    logic [31:0] ctag;
    logic [31:0] residue;
    logic [7:0]  st;
    logic        len_ok;
    logic [12:0] moved;
    logic        lerr;
    fix_t        fix;
  } req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_action = '0;
  logic        in_write = 1'b0;
  logic [63:0] in_lba = '0;
  logic [31:0] in_block_count = '0;
  logic [31:0] in_csw_signature = '0;
  logic [31:0] in_csw_tag = '0;
  logic [31:0] in_csw_residue = '0;
  logic [7:0]  in_csw_status = '0;
  logic        in_csw_length_ok = 1'b0;
  logic [12:0] in_data_bytes_moved = '0;
  logic        in_link_error = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_kind;
  logic [2:0]  out_status_code;
  logic [31:0] out_tag;
  logic [12:0] out_data_length;
  logic        out_direction_in;
  logic [4:0]  out_cdb_length;
  logic [7:0]  out_opcode;
  logic [63:0] out_cmd_lba;
  logic [3:0]  out_cmd_blocks;
  logic        out_abort_link;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  bulk_only_transport_command_engine i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // disk configuration and sequencing state as the predictor sees it
  logic [3:0]  sect_log2 = 4'd9;
  logic [63:0] disk_sectors = '0;
  logic        flush_ok = 1'b0;
  logic [31:0] tag_ctr = '0;
  logic        link_down = 1'b0;
  logic        seq_busy = 1'b0;
  logic [63:0] seq_lba = '0;
  logic [31:0] seq_left = '0;
  logic        seq_wr = 1'b0;
  int unsigned seq_chunk = 0;
  int unsigned seq_bytes = 0;

  req_t pending[$];
  botc_pkg::res_t wrappers_due[$];
  req_t cur_req;
  int   n_items = 0;
  int   errs = 0;
  int   send_idle = 0;
  int   recv_idle = 0;

  task automatic flag(string msg);
    $display("MISMATCH: %s", msg);
    errs++;
  endtask

  function automatic int unsigned eff_shift();
    if (sect_log2 < 4'd9) return 9;
    if (sect_log2 > 4'd12) return 12;
    return sect_log2;
  endfunction

  function automatic botc_pkg::res_t final_res(logic [2:0] code, logic abort);
    botc_pkg::res_t r;
    r = '0;
    r.kind = botc_pkg::KIND_FINAL;
    r.status_code = code;
    r.abort_link = abort;
    return r;
  endfunction

  function automatic botc_pkg::res_t cmd_res(logic [12:0] len, logic dir_in, logic [4:0] cdb,
                                             logic [7:0] op, logic [63:0] lba,
                                             logic [3:0] blocks);
    botc_pkg::res_t r;
    r = '0;
    r.kind = botc_pkg::KIND_CMD;
    r.status_code = botc_pkg::ST_OK;
    r.tag = tag_ctr;
    r.data_length = len;
    r.direction_in = dir_in;
    r.cdb_length = cdb;
    r.opcode = op;
    r.cmd_lba = lba;
    r.cmd_blocks = blocks;
    return r;
  endfunction

  function automatic botc_pkg::res_t next_chunk();
    int unsigned s, per, n, bytes;
    s = eff_shift();
    per = botc_pkg::MaxChunkBytes >> s;
    if (per == 0) per = 1;
    n = (seq_left < per) ? seq_left : per;
    bytes = n << s;
    if (bytes > 4096) begin
      seq_busy = 1'b0;
      return final_res(botc_pkg::ST_IO, 1'b0);
    end
    seq_busy = 1'b1;
    tag_ctr = tag_ctr + 1;
    seq_chunk = n;
    seq_bytes = bytes;
    // READ/WRITE(10) only while the whole chunk stays under the 32-bit LBA limit
    if (seq_lba <= 64'hffff_ffff && 64'(n - 1) <= 64'hffff_ffff - seq_lba)
      return cmd_res(13'(bytes), !seq_wr, botc_pkg::CDB_10,
                     seq_wr ? botc_pkg::OP_WR10 : botc_pkg::OP_RD10, seq_lba, 4'(n));
    return cmd_res(13'(bytes), !seq_wr, botc_pkg::CDB_16,
                   seq_wr ? botc_pkg::OP_WR16 : botc_pkg::OP_RD16, seq_lba, 4'(n));
  endfunction

  function automatic botc_pkg::res_t status_result(req_t r);
    int unsigned bytes, actual;
    logic broken;
    bytes = seq_bytes;
    actual = (bytes != 0) ? r.moved : 0;
    broken = r.lerr || !r.len_ok;
    if (bytes != 0 && seq_wr && actual != bytes) broken = 1'b1;
    if (r.sig != botc_pkg::CSW_SIG || r.ctag != tag_ctr || r.st > 8'd2 || r.residue > bytes ||
        actual > bytes || (r.st == 8'd0 && r.residue != bytes - actual) || r.st == 8'd2)
      broken = 1'b1;
    if (broken) begin
      link_down = 1'b1;
      seq_busy = 1'b0;
      return final_res(botc_pkg::ST_IO, 1'b1);
    end
    if (r.st != 8'd0 || actual != bytes) begin
      seq_busy = 1'b0;
      return final_res(botc_pkg::ST_IO, 1'b0);
    end
    seq_lba = seq_lba + seq_chunk;
    seq_left = seq_left - seq_chunk;
    if (seq_left == 0) begin
      seq_busy = 1'b0;
      return final_res(botc_pkg::ST_OK, 1'b0);
    end
    return next_chunk();
  endfunction

  function automatic botc_pkg::res_t predict_result(req_t r);
    case (r.action)
      botc_pkg::ACT_XFER: begin
        if (seq_busy) return final_res(botc_pkg::ST_BUSY, 1'b0);
        if (r.cnt == 0 || r.lba >= disk_sectors || {32'd0, r.cnt} > disk_sectors - r.lba)
          return final_res(botc_pkg::ST_INVALID, 1'b0);
        if (r.wr && !flush_ok) return final_res(botc_pkg::ST_RO, 1'b0);
        if (link_down) return final_res(botc_pkg::ST_IO, 1'b0);
        seq_wr = r.wr;
        seq_lba = r.lba;
        seq_left = r.cnt;
        return next_chunk();
      end
      botc_pkg::ACT_STATUS: begin
        if (!seq_busy) return final_res(botc_pkg::ST_UNEXP, 1'b0);
        return status_result(r);
      end
      botc_pkg::ACT_FLUSH: begin
        if (seq_busy) return final_res(botc_pkg::ST_BUSY, 1'b0);
        if (!flush_ok) return final_res(botc_pkg::ST_RO, 1'b0);
        if (link_down) return final_res(botc_pkg::ST_IO, 1'b0);
        seq_busy = 1'b1;
        seq_wr = 1'b1;
        seq_lba = '0;
        seq_left = '0;
        seq_chunk = 0;
        seq_bytes = 0;
        tag_ctr = tag_ctr + 1;
        return cmd_res('0, 1'b0, botc_pkg::CDB_10, botc_pkg::OP_SYNC, '0, '0);
      end
      default: return final_res(botc_pkg::ST_INVALID, 1'b0);
    endcase
  endfunction

  // fill in the status wrapper from the exchange that is open right now
  function automatic req_t fill_status(req_t r);
    if (r.fix == FIX_NONE) return r;
    r.sig = botc_pkg::CSW_SIG;
    r.ctag = tag_ctr;
    r.st = 8'd0;
    r.len_ok = 1'b1;
    r.lerr = 1'b0;
    r.moved = 13'(seq_bytes);
    r.residue = '0;
    if (r.fix == FIX_SHORT) begin
      r.moved = (seq_bytes != 0) ? 13'($urandom_range(seq_bytes - 1, 0)) : 13'd0;
      r.residue = seq_bytes - r.moved;
    end else if (r.fix == FIX_FAILED) begin
      r.st = 8'd1;
      r.residue = $urandom_range(seq_bytes, 0);
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin : drv_blk
    req_t nxt;
    logic push_nxt;
    push_nxt = 1'b0;
    if (rst_n) begin
      if (in_push && !in_full) wrappers_due.push_back(predict_result(cur_req));
      if (in_push && in_full) begin
        push_nxt = 1'b1;
      end else if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        nxt = fill_status(pending.pop_front());
        cur_req = nxt;
        push_nxt = 1'b1;
        in_action <= nxt.action;
        in_write <= nxt.wr;
        in_lba <= nxt.lba;
        in_block_count <= nxt.cnt;
        in_csw_signature <= nxt.sig;
        in_csw_tag <= nxt.ctag;
        in_csw_residue <= nxt.residue;
        in_csw_status <= nxt.st;
        in_csw_length_ok <= nxt.len_ok;
        in_data_bytes_moved <= nxt.moved;
        in_link_error <= nxt.lerr;
      end
    end
    in_push <= push_nxt;
  end

  task automatic chk(string f, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag($sformatf("%s got %0h want %0h", f, got, want));
  endtask

  // result monitor
  always @(posedge clk) begin : mon_blk
    botc_pkg::res_t w;
    if (rst_n && out_pop && !out_empty) begin
      if (wrappers_due.size() == 0) begin
        flag("result with nothing outstanding");
      end else begin
        w = wrappers_due.pop_front();
        chk("kind", 64'(out_kind), 64'(w.kind));
        chk("status_code", 64'(out_status_code), 64'(w.status_code));
        chk("tag", 64'(out_tag), 64'(w.tag));
        chk("data_length", 64'(out_data_length), 64'(w.data_length));
        chk("direction_in", 64'(out_direction_in), 64'(w.direction_in));
        chk("cdb_length", 64'(out_cdb_length), 64'(w.cdb_length));
        chk("opcode", 64'(out_opcode), 64'(w.opcode));
        chk("cmd_lba", out_cmd_lba, w.cmd_lba);
        chk("cmd_blocks", 64'(out_cmd_blocks), 64'(w.cmd_blocks));
        chk("abort_link", 64'(out_abort_link), 64'(w.abort_link));
      end
    end
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t noise(logic [1:0] act);
    req_t r;
    r.action = act;
    r.wr = 1'($urandom_range(1, 0));
    r.lba = rand64();
    r.cnt = $urandom();
    r.sig = $urandom_range(3, 0) == 0 ? botc_pkg::CSW_SIG : $urandom();
    r.ctag = $urandom();
    r.residue = $urandom();
    r.st = 8'($urandom());
    r.len_ok = 1'($urandom_range(1, 0));
    r.moved = 13'($urandom_range(4096, 0));
    r.lerr = 1'($urandom_range(1, 0));
    r.fix = FIX_NONE;
    return r;
  endfunction

  task automatic add(req_t r);
    pending.push_back(r);
    n_items++;
  endtask

  task automatic add_status(fix_t f);
    req_t r;
    r = noise(botc_pkg::ACT_STATUS);
    r.fix = f;
    add(r);
  endtask

  // transfer request followed by its chunk statuses; end: good, short or failed
  task automatic add_xfer(logic wr, logic [63:0] lba, logic [31:0] cnt, fix_t last_fix,
                          logic with_busy);
    req_t r;
    longint unsigned per, chunks;
    r = noise(botc_pkg::ACT_XFER);
    r.wr = wr;
    r.lba = lba;
    r.cnt = cnt;
    add(r);
    if (with_busy)
      add(noise($urandom_range(1, 0) ? botc_pkg::ACT_XFER : botc_pkg::ACT_FLUSH));
    per = botc_pkg::MaxChunkBytes >> eff_shift();
    chunks = (cnt + per - 1) / per;
    if (chunks > 6) begin
      chunks = $urandom_range(5, 1);
      last_fix = FIX_FAILED;
    end
    for (int i = 1; i < chunks; i++) add_status(FIX_GOOD);
    if (chunks > 0) add_status(last_fix);
  endtask

  task automatic add_flush();
    add(noise(botc_pkg::ACT_FLUSH));
    add_status(FIX_GOOD);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      botc_pkg::CFG_SSLOG2: sect_log2 = val[3:0];
      botc_pkg::CFG_TOTAL:  disk_sectors = val;
      botc_pkg::CFG_FLUSH:  flush_ok = val[0];
      default: ;
    endcase
  endtask

  task automatic set_disk(logic [3:0] sl, logic [63:0] tot, logic fl);
    cfg_write(botc_pkg::CFG_SSLOG2, {60'd0, sl});
    cfg_write(botc_pkg::CFG_TOTAL, tot);
    cfg_write(botc_pkg::CFG_FLUSH, {63'd0, fl});
  endtask

  // hold the sender until every outstanding result is back
  task automatic drain();
    do @(posedge clk); while (pending.size() != 0 || in_push || wrappers_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idle(int ph);
    case (ph % 4)
      0: begin send_idle = 0;  recv_idle = 0;  end
      1: begin send_idle = 69; recv_idle = 0;  end
      2: begin send_idle = 0;  recv_idle = 69; end
      default: begin send_idle = 30; recv_idle = 30; end
    endcase
  endtask

  function automatic logic [63:0] pick_lba();
    logic [63:0] l;
    if (disk_sectors == 0) return rand64();
    l = rand64() % disk_sectors;
    if ($urandom_range(4, 0) == 0 && 64'h1_0000_0000 - 8 < disk_sectors)
      l = 64'h1_0000_0000 - $urandom_range(8, 0);
    return l;
  endfunction

  task automatic random_phase(int target);
    int rr;
    logic [31:0] cnt;
    req_t r;
    while (n_items < target) begin
      rr = $urandom_range(99);
      cnt = ($urandom_range(19, 0) == 0) ? $urandom() : $urandom_range(40, 1);
      if (rr < 55) begin
        add_xfer(flush_ok ? 1'($urandom_range(1, 0)) : ($urandom_range(9, 0) == 0),
                 pick_lba(), cnt, FIX_GOOD, 1'b0);
      end else if (rr < 63) begin
        add_flush();
      end else if (rr < 70) begin
        if ($urandom_range(1, 0)) add_xfer(1'b0, pick_lba(), cnt, FIX_SHORT, 1'b0);
        else add_xfer(flush_ok, pick_lba(), cnt, FIX_FAILED, 1'b0);
      end else if (rr < 76) begin
        add_xfer(1'b0, pick_lba(), cnt, FIX_GOOD, 1'b1);
      end else if (rr < 86) begin
        // random request that may by chance be valid: close it off
        add(noise($urandom_range(1, 0) ? botc_pkg::ACT_XFER : botc_pkg::ACT_FLUSH));
        add_status(FIX_FAILED);
      end else if (rr < 93) begin
        add(noise(botc_pkg::ACT_STATUS));
      end else begin
        r = noise(2'd3);
        add(r);
      end
    end
  endtask

  initial begin
    req_t r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(0);

    // reset configuration: empty disk, no writes
    add_xfer(1'b0, '0, 32'd1, FIX_GOOD, 1'b0);
    add_flush();
    add(noise(botc_pkg::ACT_STATUS));
    r = noise(2'd3);
    add(r);
    drain();

    set_disk(4'd9, 64'd1000, 1'b1);
    set_idle(1);
    add_xfer(1'b0, '0, 32'd8, FIX_GOOD, 1'b0);
    add_xfer(1'b1, 64'd10, 32'd9, FIX_GOOD, 1'b0);
    add_flush();
    add_xfer(1'b0, 64'd5, 32'd0, FIX_GOOD, 1'b0);
    add_xfer(1'b0, 64'd999, 32'd1, FIX_GOOD, 1'b0);
    add_xfer(1'b0, 64'd999, 32'd2, FIX_GOOD, 1'b0);
    add_xfer(1'b0, 64'd1000, 32'd1, FIX_GOOD, 1'b0);
    add_xfer(1'b0, 64'd3, 32'd20, FIX_GOOD, 1'b1);
    add_xfer(1'b0, 64'd0, 32'd12, FIX_SHORT, 1'b0);
    add_xfer(1'b1, 64'd0, 32'd4, FIX_FAILED, 1'b0);
    drain();

    set_disk(4'd12, '1, 1'b0);
    set_idle(2);
    add_xfer(1'b0, 64'hffff_ffff, 32'd2, FIX_GOOD, 1'b0);
    add_xfer(1'b0, 64'hffff_fffe, 32'd1, FIX_GOOD, 1'b0);
    add_xfer(1'b0, 64'hffff_ffff_ffff_fffe, 32'd1, FIX_GOOD, 1'b0);
    add_xfer(1'b0, '0, 32'hffff_ffff, FIX_GOOD, 1'b0);
    add_xfer(1'b1, 64'd7, 32'd1, FIX_GOOD, 1'b0);
    add_flush();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_disk(4'd0, 64'd5000, 1'b1);
        1: set_disk(4'd15, '1, 1'b1);
        2: set_disk(4'd10, rand64(), 1'b0);
        3: set_disk(4'd11, 64'h1_0000_0010, 1'b1);
        default: set_disk(4'($urandom_range(15, 0)),
                          $urandom_range(1, 0) ? rand64() : 64'($urandom_range(5000, 1)),
                          $urandom_range(3, 0) != 0);
      endcase
      set_idle(ph);
      random_phase(30 + (ph + 1) * 176);
      drain();
    end

    // a short write breaks the link on purpose; all after it sees a dead link
    set_disk(4'd9, '1, 1'b1);
    set_idle(3);
    add_xfer(1'b0, '0, 32'd1, FIX_GOOD, 1'b0);
    add(noise(botc_pkg::ACT_STATUS));
    add_xfer(1'b1, 64'd4, 32'd2, FIX_SHORT, 1'b0);
    add_xfer(1'b0, 64'd4, 32'd2, FIX_GOOD, 1'b0);
    add_flush();
    for (int i = 0; i < 10; i++) add(noise(2'($urandom_range(3, 0))));
    drain();
    repeat (10) @(posedge clk);

    if (errs == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
